// ===== hw/rtl/pau_pkg.sv =====
// Shared types and constants for the Pareto archive update block.
`timescale 1ns / 1ps
package pau_pkg;

	localparam int NUM_OBJ = 8;
	localparam int DEPTH   = 64;
	localparam int VW      = 32;
	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_REJECTED = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_READ_OK  = 3'd3;
	localparam logic [2:0] ST_BAD_IDX  = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_RD,
		S_RDATA,
		S_EMIT
	} state_t;

	// per-objective comparison of candidate against a stored entry
	typedef struct packed {
		logic worse;
		logic better;
		logic differ;
	} lane_flags_t;

	typedef struct packed {
		logic cand_dom;
		logic blocked;
	} merge_t;

endpackage

// ===== hw/rtl/pareto_archive_update.sv =====
// Top level of the Pareto archive update block.
// Holds up to 64 mutually non-dominated vectors of eight signed 32-bit
// objectives, one storage column and comparator per objective. An insert
// scans every held entry, one per cycle, removing dominated entries in
// place. One request is worked at a time; a new request is taken while
// the previous result waits on the output.
`timescale 1ns / 1ps
module pareto_archive_update (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// request stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [263:0] s_tdata,  // entry_index, obj_0 .. obj_7, zero pad
	input  logic [1:0]   s_tuser,  // req_type
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [271:0] m_tdata,  // removed_count, archive_count, out_obj_0 .. out_obj_7, pad
	output logic [2:0]   m_tuser   // status
);
	import pau_pkg::*;

	state_t        state_q, state_d;
	logic [3:0]    obj_cnt_q;
	logic [7:0]    min_mask_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic [CW-1:0] rem_q;
	logic          blk_q;
	logic          pend_s1;
	logic          out_valid_q;

	logic [AW-1:0] idx_q;
	logic [VW-1:0] cand_q [NUM_OBJ];

	logic [2:0]    res_status_q;
	logic [CW-1:0] res_rem_q;
	logic [CW-1:0] res_cnt_q;
	logic [VW-1:0] res_obj_q [NUM_OBJ];

	logic [2:0]    out_status_q;
	logic [CW-1:0] out_rem_q;
	logic [CW-1:0] out_cnt_q;
	logic [VW-1:0] out_obj_q [NUM_OBJ];

	logic          in_fire;
	logic          out_free;
	logic          scan_rd;
	logic          eval;
	logic          keep;
	logic          append;
	logic          we;
	logic [AW-1:0] raddr;
	logic [3:0]    n_used;
	logic          idx_ok;
	logic [VW-1:0] lane_rdata [NUM_OBJ];
	lane_flags_t   lane_flags [NUM_OBJ];
	merge_t        mg;

	// configuration port
	assign pready = 1'b1;
	assign prdata = paddr[2] ? {24'd0, min_mask_q} : {28'd0, obj_cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_cnt_q  <= 4'd2;
			min_mask_q <= 8'hFF;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				min_mask_q <= pwdata[7:0];
			end else begin
				obj_cnt_q <= pwdata[3:0];
			end
		end
	end

	// clamp the objective count to between one and the lane count
	always_comb begin
		if (obj_cnt_q == 4'd0) begin
			n_used = 4'd1;
		end else if (obj_cnt_q > 4'(NUM_OBJ)) begin
			n_used = 4'(NUM_OBJ);
		end else begin
			n_used = obj_cnt_q;
		end
	end

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign scan_rd  = (state_q == S_SCAN) && (rd_q < fill_q);
	assign eval     = (state_q == S_SCAN) && pend_s1;
	assign keep     = eval && !mg.cand_dom;
	assign append   = (state_q == S_DECIDE) && ((rem_q != '0) || !blk_q)
		&& (wr_q < CW'(DEPTH));
	assign we       = keep || append;
	assign raddr    = (state_q == S_SCAN) ? rd_q[AW-1:0] : idx_q;
	assign idx_ok   = {1'b0, idx_q} < fill_q;

	// one lane per objective
	for (genvar g = 0; g < NUM_OBJ; g++) begin : g_lane
		pau_lane u_lane (
			.clk      (clk),
			.we       (we),
			.keep_sel (keep),
			.waddr    (wr_q[AW-1:0]),
			.raddr    (raddr),
			.cand     (cand_q[g]),
			.used     (4'(g) < n_used),
			.minimize (min_mask_q[g]),
			.rdata    (lane_rdata[g]),
			.flags    (lane_flags[g])
		);
	end

	pau_merge u_merge (
		.flags  (lane_flags),
		.result (mg)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (s_tuser == REQ_INSERT) begin
						state_d = S_SCAN;
					end else if (s_tuser == REQ_READ) begin
						state_d = S_RD;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_SCAN: begin
				if (!scan_rd && !pend_s1) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: state_d = S_EMIT;
			S_RD:     state_d = idx_ok ? S_RDATA : S_EMIT;
			S_RDATA:  state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			rem_q       <= '0;
			blk_q       <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= scan_rd;
			if (in_fire) begin
				rd_q  <= '0;
				wr_q  <= '0;
				rem_q <= '0;
				blk_q <= 1'b0;
				if (s_tuser == REQ_CLEAR) begin
					fill_q <= '0;
				end
			end
			if (scan_rd) begin
				rd_q <= rd_q + 1'b1;
			end
			if (eval) begin
				if (mg.cand_dom) begin
					rem_q <= rem_q + 1'b1;
				end else begin
					wr_q  <= wr_q + 1'b1;
					blk_q <= blk_q | mg.blocked;
				end
			end
			if (state_q == S_DECIDE) begin
				fill_q <= wr_q + CW'(append);
			end
			// hold the result until taken
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_q <= s_tdata[AW-1:0];
			for (int i = 0; i < NUM_OBJ; i++) begin
				cand_q[i]    <= s_tdata[6 + VW*i +: VW];
				res_obj_q[i] <= '0;
			end
			res_rem_q    <= '0;
			res_cnt_q    <= (s_tuser == REQ_CLEAR) ? '0 : fill_q;
			res_status_q <= (s_tuser == REQ_CLEAR) ? ST_ACCEPTED : ST_REJECTED;
		end
		if (state_q == S_DECIDE) begin
			res_rem_q <= rem_q;
			res_cnt_q <= wr_q + CW'(append);
			if (rem_q == '0 && blk_q) begin
				res_status_q <= ST_REJECTED;
			end else if (wr_q >= CW'(DEPTH)) begin
				res_status_q <= ST_FULL;
			end else begin
				res_status_q <= ST_ACCEPTED;
			end
		end
		if (state_q == S_RD) begin
			res_status_q <= idx_ok ? ST_READ_OK : ST_BAD_IDX;
		end
		if (state_q == S_RDATA) begin
			for (int i = 0; i < NUM_OBJ; i++) begin
				res_obj_q[i] <= lane_rdata[i];
			end
		end
		if (state_q == S_EMIT && out_free) begin
			out_status_q <= res_status_q;
			out_rem_q    <= res_rem_q;
			out_cnt_q    <= res_cnt_q;
			for (int i = 0; i < NUM_OBJ; i++) begin
				out_obj_q[i] <= res_obj_q[i];
			end
		end
	end

	// pack the result
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	always_comb begin
		m_tdata = '0;
		m_tdata[6:0]  = out_rem_q;
		m_tdata[13:7] = out_cnt_q;
		for (int i = 0; i < NUM_OBJ; i++) begin
			m_tdata[14 + VW*i +: VW] = out_obj_q[i];
		end
	end
endmodule

// ===== hw/rtl/pau_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/pau_lane.sv =====
// One objective lane: storage column plus comparator against the candidate.
`timescale 1ns / 1ps
module pau_lane (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     keep_sel,
	input  logic [pau_pkg::AW-1:0]   waddr,
	input  logic [pau_pkg::AW-1:0]   raddr,
	input  logic [pau_pkg::VW-1:0]   cand,
	input  logic                     used,
	input  logic                     minimize,
	output logic [pau_pkg::VW-1:0]   rdata,
	output pau_pkg::lane_flags_t     flags
);
	import pau_pkg::*;

	logic [VW-1:0] wdata;
	logic          lt;
	logic          gt;

	// rewrite the kept entry when compacting, else store the candidate
	assign wdata = keep_sel ? rdata : cand;

	pau_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// signed compare of candidate against entry
	assign lt = $signed(cand) < $signed(rdata);
	assign gt = $signed(cand) > $signed(rdata);

	always_comb begin
		flags.worse  = used & (minimize ? gt : lt);
		flags.better = used & (minimize ? lt : gt);
		flags.differ = used & (lt | gt);
	end
endmodule

// ===== hw/rtl/pau_merge.sv =====
// Combine lane comparison flags into dominance decisions.
`timescale 1ns / 1ps
module pau_merge (
	input  pau_pkg::lane_flags_t flags [pau_pkg::NUM_OBJ],
	output pau_pkg::merge_t      result
);
	import pau_pkg::*;

	logic any_worse;
	logic any_better;
	logic any_differ;

	always_comb begin
		any_worse  = 1'b0;
		any_better = 1'b0;
		any_differ = 1'b0;
		for (int i = 0; i < NUM_OBJ; i++) begin
			any_worse  = any_worse | flags[i].worse;
			any_better = any_better | flags[i].better;
			any_differ = any_differ | flags[i].differ;
		end
		result.cand_dom = !any_worse && any_differ;
		// entry equal to or dominating the candidate
		result.blocked  = !any_better;
	end
endmodule

// ===== verif/tb_pareto_archive_update.sv =====
// Testbench for the Pareto archive update block: directed and random requests checked by a scoreboard.
`timescale 1ns / 1ps
module tb_pareto_archive_update;
	import pau_pkg::*;

	localparam int REG_OBJ_COUNT = 0;
	localparam int REG_MIN_MASK  = 1;
	localparam int WATCHDOG_MAX  = 20000;

	typedef struct {
		logic [1:0]  req;
		logic [5:0]  idx;
		logic [31:0] obj [NUM_OBJ];
	} request_t;

	typedef struct {
		logic [2:0]  status;
		logic [6:0]  removed;
		logic [6:0]  fill;
		logic [31:0] obj [NUM_OBJ];
	} outcome_t;

	// Archive predictor and queue of expected outcomes
	class archive_scoreboard;
		logic [31:0] entries [DEPTH][NUM_OBJ];
		int fill;
		int obj_count;
		logic [7:0] min_mask;
		outcome_t expected_q [$];
		int mismatches;
		int checked;
		int n_removed;
		int n_full;
		int n_rejected;

		function new();
			fill = 0;
			obj_count = 2;
			min_mask = 8'hFF;
			mismatches = 0;
			checked = 0;
			n_removed = 0;
			n_full = 0;
			n_rejected = 0;
		endfunction

		function int used_count();
			if (obj_count == 0)
				return 1;
			if (obj_count > NUM_OBJ)
				return NUM_OBJ;
			return obj_count;
		endfunction

		// true when vector a dominates vector b over the used objectives
		function bit beats(logic [31:0] a [NUM_OBJ], logic [31:0] b [NUM_OBJ]);
			bit differ;
			differ = 0;
			for (int i = 0; i < used_count(); i++) begin
				if (min_mask[i] ? ($signed(a[i]) > $signed(b[i]))
						: ($signed(a[i]) < $signed(b[i])))
					return 0;
				if (a[i] != b[i])
					differ = 1;
			end
			return differ;
		endfunction

		function bit same(logic [31:0] a [NUM_OBJ], logic [31:0] b [NUM_OBJ]);
			for (int i = 0; i < used_count(); i++)
				if (a[i] != b[i])
					return 0;
			return 1;
		endfunction

		function void note_request(request_t r);
			outcome_t o;
			int w;
			bit blocked;
			o.status = ST_REJECTED;
			o.removed = 0;
			foreach (o.obj[i])
				o.obj[i] = 0;
			case (r.req)
				REQ_INSERT: begin
					w = 0;
					blocked = 0;
					for (int k = 0; k < fill; k++) begin
						if (beats(r.obj, entries[k])) begin
							o.removed++;
							continue;
						end
						if (same(r.obj, entries[k]) || beats(entries[k], r.obj))
							blocked = 1;
						entries[w] = entries[k];
						w++;
					end
					fill = w;
					if (o.removed == 0 && blocked) begin
						o.status = ST_REJECTED;
						n_rejected++;
					end else if (fill >= DEPTH) begin
						o.status = ST_FULL;
						n_full++;
					end else begin
						entries[fill] = r.obj;
						fill++;
						o.status = ST_ACCEPTED;
					end
					if (o.removed != 0)
						n_removed++;
				end
				REQ_READ: begin
					if (r.idx < fill) begin
						o.status = ST_READ_OK;
						o.obj = entries[r.idx];
					end else begin
						o.status = ST_BAD_IDX;
					end
				end
				REQ_CLEAR: begin
					fill = 0;
					o.status = ST_ACCEPTED;
				end
				default: o.status = ST_REJECTED;
			endcase
			o.fill = fill;
			expected_q.insert(expected_q.size(), o);
		endfunction

		function void check_result(outcome_t got);
			outcome_t e;
			bit bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d fill %0d", got.status, got.fill);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			bad = (e.status != got.status) || (e.removed != got.removed) ||
				(e.fill != got.fill);
			foreach (e.obj[i])
				if (e.obj[i] != got.obj[i])
					bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch #%0d: exp status %0d removed %0d fill %0d",
						checked, e.status, e.removed, e.fill);
					$display("              got status %0d removed %0d fill %0d",
						got.status, got.removed, got.fill);
					foreach (e.obj[i])
						if (e.obj[i] != got.obj[i])
							$display("   obj %0d exp %h got %h", i, e.obj[i], got.obj[i]);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid, s_tready;
	logic [263:0] s_tdata;  // entry_index, obj_0 .. obj_7, zero pad
	logic [1:0] s_tuser;    // req_type
	logic m_tvalid, m_tready;
	logic [271:0] m_tdata;  // removed_count, archive_count, out_obj_0 .. out_obj_7, pad
	logic [2:0] m_tuser;    // status

	archive_scoreboard sb;
	bit quiet;
	int idle_cycles;
	int bursts_left;

	pareto_archive_update u_dut (.*);

	initial clk = 0;
	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Collect result transactions and apply random backpressure
	always @(posedge clk) begin
		outcome_t got;
		if (m_tvalid && m_tready) begin
			got.removed = m_tdata[6:0];
			got.fill = m_tdata[13:7];
			foreach (got.obj[i])
				got.obj[i] = m_tdata[14 + 32*i +: 32];
			got.status = m_tuser;
			sb.check_result(got);
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (bursts_left > 0) begin
			bursts_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			bursts_left = $urandom_range(1, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("watchdog expired, %0d results outstanding", sb.expected_q.size());
			$display("tb_pareto_archive_update failed");
			$finish;
		end
	end

	task automatic write_reg(int index, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * index);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == REG_OBJ_COUNT)
			sb.obj_count = value[3:0];
		else
			sb.min_mask = value[7:0];
	endtask

	// Present one request and hold it until accepted; valid stays up between
	// back-to-back requests
	task automatic send_request(request_t r);
		int gap;
		logic [263:0] data;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data = '0;
		data[5:0] = r.idx;
		foreach (r.obj[i])
			data[6 + 32*i +: 32] = r.obj[i];
		s_tvalid <= 1'b1;
		s_tuser <= r.req;
		s_tdata <= data;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(r);
	endtask

	// Drop valid, wait for every outstanding result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value(int spread);
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom();
			default: return 32'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	function automatic request_t make_request(int spread);
		request_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.req = (pick < 75) ? REQ_INSERT : (pick < 96) ? REQ_READ
			: (pick < 99) ? REQ_CLEAR : 2'd3;
		r.idx = (pick % 4 == 0) ? 6'($urandom()) : 6'($urandom_range(0, sb.fill));
		foreach (r.obj[i])
			r.obj[i] = pick_value(spread);
		return r;
	endfunction

	initial begin
		request_t r;
		int spread;
		sb = new();
		quiet = 0;
		idle_cycles = 0;
		bursts_left = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = REQ_INSERT;
		m_tready = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// Directed: empty archive, extremes, equality, dominance, reads, clear
		foreach (r.obj[i])
			r.obj[i] = 32'h8000_0000;
		r.idx = 0;
		r.req = REQ_READ;
		send_request(r);
		r.req = REQ_INSERT;
		send_request(r);
		send_request(r);
		foreach (r.obj[i])
			r.obj[i] = 32'h7FFF_FFFF;
		send_request(r);
		r.obj[0] = 32'hFFFF_FFFF;
		r.obj[1] = 32'h0000_0001;
		send_request(r);
		r.obj[0] = 32'h8000_0000;
		r.obj[1] = 32'h8000_0000;
		r.obj[5] = 32'h1234_5678;
		send_request(r);
		for (int k = 0; k < 3; k++) begin
			r.req = REQ_READ;
			r.idx = k;
			send_request(r);
		end
		r.idx = 63;
		send_request(r);
		r.req = 2'd3;
		send_request(r);
		r.req = REQ_CLEAR;
		send_request(r);
		r.req = REQ_READ;
		r.idx = 0;
		send_request(r);
		drain();

		// Fill the archive with a trade-off front, then overflow it
		write_reg(REG_OBJ_COUNT, 2);
		write_reg(REG_MIN_MASK, 8'hFF);
		for (int k = 0; k < DEPTH + 2; k++) begin
			r.req = REQ_INSERT;
			foreach (r.obj[i])
				r.obj[i] = $urandom();
			r.obj[0] = k;
			r.obj[1] = 1000 - k;
			send_request(r);
		end
		r.obj[0] = -5;
		r.obj[1] = -5;
		send_request(r);
		drain();

		// Random phases over several settings, extremes included
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: write_reg(REG_OBJ_COUNT, 0);
				1: write_reg(REG_OBJ_COUNT, 8);
				2: write_reg(REG_OBJ_COUNT, 15);
				3: write_reg(REG_OBJ_COUNT, 1);
				default: write_reg(REG_OBJ_COUNT, $urandom_range(0, 15));
			endcase
			case (phase)
				0: write_reg(REG_MIN_MASK, 8'h00);
				1: write_reg(REG_MIN_MASK, 8'hFF);
				default: write_reg(REG_MIN_MASK, $urandom_range(0, 255));
			endcase
			quiet = (phase == 9);
			spread = (phase % 2 == 0) ? 3 : 40;
			for (int k = 0; k < 125; k++)
				send_request(make_request(spread));
			drain();
		end

		$display("checked %0d results: %0d inserts removed entries, %0d rejected, %0d full",
			sb.checked, sb.n_removed, sb.n_rejected, sb.n_full);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("tb_pareto_archive_update passed");
		else
			$display("tb_pareto_archive_update failed");
		$finish;
	end

endmodule
